[hw/rtl/gsa_pkg.sv]
`default_nettype none

package gsa_pkg;

    // fixed field widths of the item and result transfers
    localparam int IDX_W  = 10;
    localparam int GEN_W  = 16;
    localparam int TEAM_W = 2;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 11;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
    localparam logic [OP_W-1:0] OP_ACTIVATE = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
    localparam logic [OP_W-1:0] OP_VALIDATE = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch item, issue slot and stack reads
        logic rd_pop;  // re-read slot table at the popped index
        logic commit;  // write back, update counters, load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pop_needed;  // allocate served from the free stack
        logic out_busy;    // result register full and stalled
    } t_stat;

endpackage

`default_nettype wire

[hw/rtl/gsa_controller.sv]
`default_nettype none

module gsa_controller (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire gsa_pkg::t_stat i_stat,
    output gsa_pkg::t_cmd      o_cmd
);
    import gsa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.pop_needed) begin
                    o_cmd.rd_pop = 1'b1;
                    n_state      = S_POP;
                end else if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_POP: begin
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

[hw/rtl/gsa_datapath.sv]
`default_nettype none

module gsa_datapath #(
    parameter int SLOTS    = 1024,
    parameter int GEN_BITS = 16,
    parameter int TEAMS    = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gsa_pkg::t_cmd                 i_cmd,
    output gsa_pkg::t_stat                     o_stat,
    input  wire logic [gsa_pkg::OP_W-1:0]      i_op,
    input  wire logic [gsa_pkg::IDX_W-1:0]     i_slot_index,
    input  wire logic [gsa_pkg::GEN_W-1:0]     i_handle_generation,
    input  wire logic [gsa_pkg::TEAM_W-1:0]    i_team,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic [gsa_pkg::STAT_W-1:0]         o_status,
    output logic [gsa_pkg::IDX_W-1:0]          o_out_index,
    output logic [gsa_pkg::GEN_W-1:0]          o_out_generation,
    output logic                               o_handle_ok,
    output logic [gsa_pkg::CNT_W-1:0]          o_alive_total,
    output logic [gsa_pkg::CNT_W-1:0]          o_team_alive
);
    import gsa_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = $clog2(TEAMS);
    localparam int GB = GEN_BITS;
    localparam int EW = 1 + TW + GB;   // {alive, team, generation}

    // slot table and free stack
    logic [EW-1:0] slot_mem  [SLOTS];
    logic [AW-1:0] stack_mem [SLOTS];

    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [GEN_W-1:0]  r_gen;
    logic [TEAM_W-1:0] r_team;
    logic [EW-1:0]     r_slot_rd;
    logic [AW-1:0]     r_stack_rd;

    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_top, n_top;
    logic [CW-1:0] r_alive_cnt, n_alive_cnt;
    logic [CW-1:0] r_team_cnt [TEAMS];
    logic [CW-1:0] n_team_cnt [TEAMS];

    logic r_out_valid;

    // width adaptation
    logic [AW+IDX_W-1:0]  w_in_ext, w_idx_ext;
    logic [AW-1:0]        w_in_addr, w_idx_addr;
    logic [CW-1:0]        w_top_m1;
    logic [GB+GEN_W-1:0]  w_hgen_ext;
    logic [GB-1:0]        w_hgen_trunc;
    logic [TW+TEAM_W-1:0] w_team_ext;
    logic [TW-1:0]        w_team_addr;

    assign w_in_ext     = {{AW{1'b0}}, i_slot_index};
    assign w_in_addr    = w_in_ext[AW-1:0];
    assign w_idx_ext    = {{AW{1'b0}}, r_idx};
    assign w_idx_addr   = w_idx_ext[AW-1:0];
    assign w_top_m1     = r_top - CW'(1);
    assign w_hgen_ext   = {{GB{1'b0}}, r_gen};
    assign w_hgen_trunc = w_hgen_ext[GB-1:0];
    assign w_team_ext   = {{TW{1'b0}}, r_team};
    assign w_team_addr  = w_team_ext[TW-1:0];

    // slot entry fields
    logic          s_alive;
    logic [TW-1:0] s_team;
    logic [GB-1:0] s_gen;
    assign s_alive = r_slot_rd[EW-1];
    assign s_team  = r_slot_rd[GB +: TW];
    assign s_gen   = r_slot_rd[GB-1:0];

    logic w_exists, w_team_ok, w_gen_match, w_handle_ok, w_not_full, w_pop;
    assign w_exists    = ({{CW{1'b0}}, r_idx} < {{IDX_W{1'b0}}, r_used});
    assign w_team_ok   = (32'(r_team) < TEAMS);
    assign w_gen_match = ({{GEN_W{1'b0}}, s_gen} == w_hgen_ext);
    assign w_handle_ok = (r_op != OP_ALLOC) && (r_gen != '0) && w_exists
                         && s_alive && w_gen_match;
    assign w_not_full  = (r_used < CW'(SLOTS));
    assign w_pop       = (r_op == OP_ALLOC) && (r_top != '0);

    assign o_stat.pop_needed = w_pop;
    assign o_stat.out_busy   = r_out_valid && i_out_stall;

    // commit-time results
    logic              w_we, w_push, w_inc_new, w_dec_old;
    logic [AW-1:0]     w_wa;
    logic [EW-1:0]     w_wd;
    logic [STAT_W-1:0] w_status;
    logic [AW-1:0]     w_oidx_slot;
    logic              w_oidx_sel;
    logic [GB-1:0]     w_ogen, w_g_act, w_g_bump, w_g_pop;
    logic [AW+IDX_W-1:0] w_oidx_ext;
    logic [IDX_W-1:0]  w_oidx;

    assign w_g_act  = (w_hgen_trunc == '0) ? GB'(1) : w_hgen_trunc;
    assign w_g_bump = ((s_gen + GB'(1)) == '0) ? GB'(1) : (s_gen + GB'(1));
    assign w_g_pop  = (s_gen == '0) ? GB'(1) : s_gen;

    always_comb begin
        n_used      = r_used;
        n_top       = r_top;
        n_alive_cnt = r_alive_cnt;
        w_we        = 1'b0;
        w_push      = 1'b0;
        w_inc_new   = 1'b0;
        w_dec_old   = 1'b0;
        w_wa        = w_idx_addr;
        w_wd        = r_slot_rd;
        w_status    = ST_OK;
        w_oidx_sel  = 1'b0;
        w_oidx_slot = w_idx_addr;
        w_ogen      = w_exists ? s_gen : '0;
        unique case (r_op)
            OP_ALLOC: begin
                w_ogen = '0;
                if (r_top != '0) begin
                    n_top       = w_top_m1;
                    w_we        = 1'b1;
                    w_wa        = r_stack_rd;
                    w_wd        = {s_alive, s_team, w_g_pop};
                    w_oidx_sel  = 1'b1;
                    w_oidx_slot = r_stack_rd;
                    w_ogen      = w_g_pop;
                end else if (w_not_full) begin
                    n_used      = r_used + CW'(1);
                    w_we        = 1'b1;
                    w_wa        = r_used[AW-1:0];
                    w_wd        = {1'b0, {TW{1'b0}}, GB'(1)};
                    w_oidx_sel  = 1'b1;
                    w_oidx_slot = r_used[AW-1:0];
                    w_ogen      = GB'(1);
                end else begin
                    w_status = ST_FULL;
                end
            end
            OP_ACTIVATE: begin
                if (!w_exists || !w_team_ok) begin
                    w_status = ST_INVALID;
                end else begin
                    if (s_alive) begin
                        w_dec_old = 1'b1;
                    end else begin
                        n_alive_cnt = r_alive_cnt + CW'(1);
                    end
                    w_inc_new = 1'b1;
                    w_we      = 1'b1;
                    w_wd      = {1'b1, w_team_addr, w_g_act};
                    w_ogen    = w_g_act;
                end
            end
            OP_REMOVE: begin
                if (!w_handle_ok) begin
                    w_status = ST_INVALID;
                end else begin
                    n_alive_cnt = r_alive_cnt - CW'(1);
                    w_dec_old   = 1'b1;
                    w_we        = 1'b1;
                    w_wd        = {1'b0, s_team, w_g_bump};
                    w_ogen      = w_g_bump;
                    if (r_top < CW'(SLOTS)) begin
                        w_push = 1'b1;
                        n_top  = r_top + CW'(1);
                    end
                end
            end
            OP_VALIDATE: begin
                if (!w_handle_ok) begin
                    w_status = ST_INVALID;
                end
            end
            default: begin
                w_status = ST_INVALID;
            end
        endcase
    end

    always_comb begin
        for (int t = 0; t < TEAMS; t++) begin
            n_team_cnt[t] = r_team_cnt[t]
                            + CW'(w_inc_new && (w_team_addr == TW'(t)))
                            - CW'(w_dec_old && (s_team == TW'(t)));
        end
    end

    assign w_oidx_ext = {{IDX_W{1'b0}}, w_oidx_slot};
    assign w_oidx     = w_oidx_sel ? w_oidx_ext[IDX_W-1:0] : r_idx;

    logic [CW-1:0]       w_team_sel;
    logic [CW+CNT_W-1:0] w_alive_ext, w_team_cnt_ext;
    logic [GB+GEN_W-1:0] w_ogen_ext;
    assign w_team_sel     = w_team_ok ? n_team_cnt[w_team_addr] : '0;
    assign w_alive_ext    = {{CNT_W{1'b0}}, n_alive_cnt};
    assign w_team_cnt_ext = {{CNT_W{1'b0}}, w_team_sel};
    assign w_ogen_ext     = {{GEN_W{1'b0}}, w_ogen};

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot_rd  <= slot_mem[w_in_addr];
            r_stack_rd <= stack_mem[w_top_m1[AW-1:0]];
        end else if (i_cmd.rd_pop) begin
            r_slot_rd  <= slot_mem[r_stack_rd];
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_we) begin
            slot_mem[w_wa] <= w_wd;
        end
        if (i_cmd.commit && w_push) begin
            stack_mem[r_top[AW-1:0]] <= w_idx_addr;
        end
    end

    // item latch and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_idx  <= i_slot_index;
            r_gen  <= i_handle_generation;
            r_team <= i_team;
        end
        if (i_cmd.commit) begin
            o_status         <= w_status;
            o_out_index      <= w_oidx;
            o_out_generation <= w_ogen_ext[GEN_W-1:0];
            o_handle_ok      <= w_handle_ok;
            o_alive_total    <= w_alive_ext[CNT_W-1:0];
            o_team_alive     <= w_team_cnt_ext[CNT_W-1:0];
        end
    end

    // counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_top       <= '0;
            r_alive_cnt <= '0;
            for (int t = 0; t < TEAMS; t++) begin
                r_team_cnt[t] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_used      <= n_used;
                r_top       <= n_top;
                r_alive_cnt <= n_alive_cnt;
                for (int t = 0; t < TEAMS; t++) begin
                    r_team_cnt[t] <= n_team_cnt[t];
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hw/rtl/generational_slot_allocator.sv]
// Sequence: an item is taken in idle, its slot and stack reads are registered for exec,
//   an allocate served from the free stack adds the pop state for a second slot read,
//   and commit writes back and loads the result register. One item is in flight: a new
//   item is taken only once the previous one has committed; commit waits on a stalled result.
// Reset: synchronous, active low; clears fill count, stack pointer and alive counters.
//   Slot table and stack are not swept: entries are gated by the fill count and pointer.
`default_nettype none

module generational_slot_allocator #(
    parameter int SLOTS    = 1024,
    parameter int GEN_BITS = 16,
    parameter int TEAMS    = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [gsa_pkg::OP_W-1:0]      i_op,
    input  wire logic [gsa_pkg::IDX_W-1:0]     i_slot_index,
    input  wire logic [gsa_pkg::GEN_W-1:0]     i_handle_generation,
    input  wire logic [gsa_pkg::TEAM_W-1:0]    i_team,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [gsa_pkg::STAT_W-1:0]         o_status,
    output logic [gsa_pkg::IDX_W-1:0]          o_out_index,
    output logic [gsa_pkg::GEN_W-1:0]          o_out_generation,
    output logic                               o_handle_ok,
    output logic [gsa_pkg::CNT_W-1:0]          o_alive_total,
    output logic [gsa_pkg::CNT_W-1:0]          o_team_alive
);
    import gsa_pkg::*;

    // Control split:
    //   controller - three-state sequencer: idle (takes a transfer), exec (slot and stack
    //                read data in hand), pop (second slot read for a stack pop).
    //   datapath   - slot table {alive, team, generation}, free stack, fill count,
    //                stack pointer, alive counters and the result register.
    // A new item is taken while the previous result is still waiting; commit only
    // holds off when the result register is full and stalled.
    t_cmd  w_cmd;
    t_stat w_stat;

    gsa_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Every slot-table read is gated by the fill count (alive, generation) or by the
    // alive bit (team), and a fresh slot is written at generation 1 with alive clear
    // when handed out, so no clearing pass is needed.
    gsa_datapath #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS),
        .TEAMS    (TEAMS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_op                (i_op),
        .i_slot_index        (i_slot_index),
        .i_handle_generation (i_handle_generation),
        .i_team              (i_team),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_status            (o_status),
        .o_out_index         (o_out_index),
        .o_out_generation    (o_out_generation),
        .o_handle_ok         (o_handle_ok),
        .o_alive_total       (o_alive_total),
        .o_team_alive        (o_team_alive)
    );

endmodule

`default_nettype wire

[hw/rtl/gsa_checker.sv]
`default_nettype none

module gsa_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [gsa_pkg::STAT_W-1:0]    o_status,
    input wire logic [gsa_pkg::GEN_W-1:0]     o_out_generation,
    input wire logic                          o_handle_ok,
    input wire logic [gsa_pkg::CNT_W-1:0]     o_alive_total,
    input wire logic [gsa_pkg::CNT_W-1:0]     o_team_alive
);
    import gsa_pkg::*;

    // one item in flight: the cycle after a transfer in, input is held off
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item taken while previous one still in flight");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
                                          && $stable(o_out_generation)))
        else $error("stalled result changed");

    // a team's count never exceeds the total
    a_team_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_team_alive <= o_alive_total))
        else $error("team alive count above total");

    // full table hands out nothing
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> ((o_out_generation == '0)
                                                    && !o_handle_ok))
        else $error("full status with a generation or valid handle");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_out_generation (o_out_generation),
    .o_handle_ok      (o_handle_ok),
    .o_alive_total    (o_alive_total),
    .o_team_alive     (o_team_alive)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import gsa_pkg::*;

    // Items are planned up front against a planning copy of the slot map, so
    // that handles can be aimed at live slots. The same stepping function is
    // run again on a checking copy as each item transfer is accepted, and the
    // results it produces wait in order for the block's result transfers.

    localparam int unsigned TABLE_SLOTS = 1024;
    localparam int unsigned TEAM_COUNT  = 4;
    localparam int unsigned QUIET_LIMIT = 4000;   // cycles with no transfer at all
    localparam int unsigned TAIL_CYCLES = 12;

    // idle profiles
    localparam int unsigned MODE_BUSY     = 0;
    localparam int unsigned MODE_SRC_IDLE = 1;
    localparam int unsigned MODE_SNK_STALL = 2;
    localparam int unsigned MODE_BOTH     = 3;

    // copies of the slot map: one for planning, one for checking
    localparam int PLAN  = 0;
    localparam int CHECK = 1;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [GEN_W-1:0]  hgen;
        logic [TEAM_W-1:0] team;
        bit                drain;   // hold until every awaited result is in
        int unsigned       mode;
    } t_slot_req;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  index;
        logic [GEN_W-1:0]  gen;
        logic              ok;
        logic [CNT_W-1:0]  total;
        logic [CNT_W-1:0]  team_live;
    } t_slot_rsp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_op = '0;
    logic [IDX_W-1:0]     i_slot_index = '0;
    logic [GEN_W-1:0]     i_handle_generation = '0;
    logic [TEAM_W-1:0]    i_team = '0;

    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [IDX_W-1:0]     o_out_index;
    logic [GEN_W-1:0]     o_out_generation;
    logic                 o_handle_ok;
    logic [CNT_W-1:0]     o_alive_total;
    logic [CNT_W-1:0]     o_team_alive;

    generational_slot_allocator #(
        .SLOTS    (TABLE_SLOTS),
        .GEN_BITS (GEN_W),
        .TEAMS    (TEAM_COUNT)
    ) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_op                (i_op),
        .i_slot_index        (i_slot_index),
        .i_handle_generation (i_handle_generation),
        .i_team              (i_team),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_out_index         (o_out_index),
        .o_out_generation    (o_out_generation),
        .o_handle_ok         (o_handle_ok),
        .o_alive_total       (o_alive_total),
        .o_team_alive        (o_team_alive)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Slot map state, one copy per world
    // ------------------------------------------------------------------
    logic [GEN_W-1:0]  gen_tab   [2][TABLE_SLOTS];
    bit                alive_tab [2][TABLE_SLOTS];
    logic [TEAM_W-1:0] team_tab  [2][TABLE_SLOTS];
    logic [IDX_W-1:0]  free_stk  [2][TABLE_SLOTS];
    int unsigned       used_cnt  [2];
    int unsigned       stack_top [2];
    int unsigned       alive_cnt [2];
    int unsigned       team_cnt  [2][TEAM_COUNT];

    t_slot_req   issue_q[$];      // planned items not yet presented
    t_slot_rsp   awaited_rsp[$];  // results owed by the block, oldest first
    t_slot_req   cur_req;
    int unsigned cur_mode = MODE_BUSY;
    int unsigned mismatches = 0;
    int unsigned rsp_seen = 0;
    int unsigned quiet_cycles = 0;

    // planning context
    int unsigned plan_mode = MODE_BUSY;
    bit          plan_drain = 1'b0;

    function automatic void clear_world(input int w);
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            gen_tab[w][k]   = '0;
            alive_tab[w][k] = 1'b0;
            team_tab[w][k]  = '0;
            free_stk[w][k]  = '0;
        end
        for (int t = 0; t < TEAM_COUNT; t++) team_cnt[w][t] = 0;
        used_cnt[w]  = 0;
        stack_top[w] = 0;
        alive_cnt[w] = 0;
    endfunction

    // One operation on the slot map of world w; returns the result it owes.
    function automatic t_slot_rsp slot_map_step(input int w, input t_slot_req rq);
        t_slot_rsp        rs;
        int unsigned      s;
        logic [GEN_W-1:0] g;
        bit               exists;
        bit               live;
        exists = rq.idx < used_cnt[w];
        // handle check always sees the state before the operation
        live = exists && rq.hgen != '0 && alive_tab[w][rq.idx]
               && gen_tab[w][rq.idx] == rq.hgen;
        rs.status = ST_OK;
        rs.index  = rq.idx;
        rs.gen    = '0;
        rs.ok     = (rq.op != OP_ALLOC) && live;
        case (rq.op)
            OP_ALLOC: begin
                if (stack_top[w] > 0) begin
                    stack_top[w]--;
                    s = 32'(free_stk[w][stack_top[w]]);
                    if (gen_tab[w][s] == '0) gen_tab[w][s] = GEN_W'(1);
                    rs.index = IDX_W'(s);
                    rs.gen   = gen_tab[w][s];
                end else if (used_cnt[w] < TABLE_SLOTS) begin
                    s = used_cnt[w];
                    used_cnt[w]++;
                    gen_tab[w][s]   = GEN_W'(1);
                    alive_tab[w][s] = 1'b0;
                    rs.index = IDX_W'(s);
                    rs.gen   = GEN_W'(1);
                end else begin
                    rs.status = ST_FULL;
                end
            end
            OP_ACTIVATE: begin
                if (!exists) begin
                    rs.status = ST_INVALID;
                end else begin
                    if (alive_tab[w][rq.idx]) team_cnt[w][team_tab[w][rq.idx]]--;
                    else alive_cnt[w]++;
                    team_cnt[w][rq.team]++;
                    alive_tab[w][rq.idx] = 1'b1;
                    team_tab[w][rq.idx]  = rq.team;
                    gen_tab[w][rq.idx]   = (rq.hgen != '0) ? rq.hgen : GEN_W'(1);
                    rs.gen = gen_tab[w][rq.idx];
                end
            end
            OP_REMOVE: begin
                if (!live) begin
                    rs.status = ST_INVALID;
                    rs.gen    = exists ? gen_tab[w][rq.idx] : '0;
                end else begin
                    g = gen_tab[w][rq.idx] + GEN_W'(1);
                    alive_tab[w][rq.idx] = 1'b0;
                    alive_cnt[w]--;
                    team_cnt[w][team_tab[w][rq.idx]]--;
                    gen_tab[w][rq.idx] = (g != '0) ? g : GEN_W'(1);
                    rs.gen = gen_tab[w][rq.idx];
                    // a full stack drops the push, the slot is still freed
                    if (stack_top[w] < TABLE_SLOTS) begin
                        free_stk[w][stack_top[w]] = rq.idx;
                        stack_top[w]++;
                    end
                end
            end
            default: begin
                if (!live) rs.status = ST_INVALID;
                rs.gen = exists ? gen_tab[w][rq.idx] : '0;
            end
        endcase
        rs.total     = CNT_W'(alive_cnt[w]);
        rs.team_live = CNT_W'(team_cnt[w][rq.team]);
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // Planning helpers
    // ------------------------------------------------------------------
    function automatic t_slot_rsp plan_req(input logic [OP_W-1:0] op,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [GEN_W-1:0] hgen,
                                           input logic [TEAM_W-1:0] team);
        t_slot_req rq;
        rq.op    = op;
        rq.idx   = idx;
        rq.hgen  = hgen;
        rq.team  = team;
        rq.drain = plan_drain;
        rq.mode  = plan_mode;
        plan_drain = 1'b0;
        issue_q = {issue_q, rq};
        return slot_map_step(PLAN, rq);
    endfunction

    // random alive slot in the planning copy, -1 when none
    function automatic int find_alive();
        int unsigned n;
        int unsigned st;
        n = used_cnt[PLAN];
        if (n == 0) return -1;
        st = $urandom_range(n - 1);
        for (int k = 0; k < n; k++)
            if (alive_tab[PLAN][(st + k) % n]) return (st + k) % n;
        return -1;
    endfunction

    // Mostly well-formed handles aimed at real slots, with some near misses
    // and some pure noise.
    function automatic void plan_random();
        int unsigned      r;
        int               a;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] hg;
        r = $urandom_range(99);
        if (r < 22) begin
            void'(plan_req(OP_ALLOC, IDX_W'($urandom), GEN_W'($urandom), TEAM_W'($urandom)));
            return;
        end
        op = (r < 48) ? OP_ACTIVATE : (r < 74) ? OP_REMOVE : OP_VALIDATE;
        a  = find_alive();
        if ($urandom_range(9) < 8 && used_cnt[PLAN] > 0) begin
            if (op != OP_ACTIVATE && a >= 0) idx = IDX_W'(a);
            else idx = IDX_W'($urandom_range(used_cnt[PLAN] - 1));
            hg = gen_tab[PLAN][idx];
            case ($urandom_range(7))
                0: hg = '0;
                1: hg = hg + GEN_W'(1);
                2: hg = GEN_W'($urandom);
                3: hg = '1;
                default: ;
            endcase
        end else begin
            idx = IDX_W'($urandom);
            hg  = GEN_W'($urandom);
        end
        void'(plan_req(op, idx, hg, TEAM_W'($urandom)));
    endfunction

    function automatic int unsigned src_gap_pct(input int unsigned m);
        return (m == MODE_SRC_IDLE) ? 51 : (m == MODE_BOTH) ? 35 : 0;
    endfunction

    function automatic int unsigned snk_stall_pct(input int unsigned m);
        return (m == MODE_SNK_STALL) ? 51 : (m == MODE_BOTH) ? 35 : 0;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("mismatch %0d at result %0d: %s", mismatches, rsp_seen, msg);
    endtask

    // four-state compare, so an unknown output bit counts as a mismatch
    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Item driver: a payload stays put until its transfer; the next one is
    // only chosen after that, so valid never drops under a stall.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_items
        t_slot_req nx;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                awaited_rsp = {awaited_rsp, slot_map_step(CHECK, cur_req)};
            if (!i_in_valid || !o_in_stall) begin
                if (issue_q.size() > 0 && !(issue_q[0].drain && awaited_rsp.size() > 0)
                    && $urandom_range(99) >= src_gap_pct(cur_mode)) begin
                    nx = issue_q.pop_front();
                    cur_req             <= nx;
                    cur_mode            <= nx.mode;
                    i_op                <= nx.op;
                    i_slot_index        <= nx.idx;
                    i_handle_generation <= nx.hgen;
                    i_team              <= nx.team;
                    i_in_valid          <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: each result transfer against the oldest awaited one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        t_slot_rsp ex;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                rsp_seen++;
                if (awaited_rsp.size() == 0) begin
                    flag_mismatch("result transfer with nothing awaited");
                end else begin
                    ex = awaited_rsp.pop_front();
                    check_field("status", 32'(o_status), 32'(ex.status));
                    check_field("out_index", 32'(o_out_index), 32'(ex.index));
                    check_field("out_generation", 32'(o_out_generation), 32'(ex.gen));
                    check_field("handle_ok", 32'(o_handle_ok), 32'(ex.ok));
                    check_field("alive_total", 32'(o_alive_total), 32'(ex.total));
                    check_field("team_alive", 32'(o_team_alive), 32'(ex.team_live));
                end
            end
            i_out_stall <= ($urandom_range(99) < snk_stall_pct(cur_mode));
        end
    end

    // watchdog: too long without any transfer means the block has hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan and end of run
    // ------------------------------------------------------------------
    initial begin
        clear_world(PLAN);
        clear_world(CHECK);

        // directed: empty map, handle checks, generation wrap, odd activates
        void'(plan_req(OP_VALIDATE, '0, '0, '0));                     // slot not there yet
        void'(plan_req(OP_ACTIVATE, IDX_W'(5), 16'h1234, TEAM_W'(1))); // never handed out
        void'(plan_req(OP_REMOVE, '0, GEN_W'(1), TEAM_W'(2)));          // nothing to remove
        void'(plan_req(OP_ALLOC, '1, '1, TEAM_W'(3)));                  // fresh slot 0
        void'(plan_req(OP_ALLOC, '0, '0, '0));                          // fresh slot 1
        void'(plan_req(OP_VALIDATE, '0, GEN_W'(1), '0));                // right gen, not alive
        void'(plan_req(OP_ACTIVATE, '0, '0, TEAM_W'(3)));               // zero gen becomes 1
        void'(plan_req(OP_VALIDATE, '0, GEN_W'(1), TEAM_W'(3)));
        void'(plan_req(OP_VALIDATE, '0, '0, TEAM_W'(3)));               // zero gen never valid
        void'(plan_req(OP_ACTIVATE, '0, 16'hFFFF, TEAM_W'(2)));         // alive: moves team
        void'(plan_req(OP_REMOVE, '0, 16'hFFFE, TEAM_W'(2)));           // stale handle
        void'(plan_req(OP_REMOVE, '0, 16'hFFFF, TEAM_W'(2)));           // gen wraps to 1
        void'(plan_req(OP_REMOVE, '0, GEN_W'(1), TEAM_W'(1)));          // already dead
        void'(plan_req(OP_ACTIVATE, '0, 16'h5A5A, TEAM_W'(1)));         // freed, stays stacked
        void'(plan_req(OP_ALLOC, '0, '0, TEAM_W'(1)));                  // pops slot 0, alive
        void'(plan_req(OP_ACTIVATE, IDX_W'(1), 16'hAAAA, '0));
        void'(plan_req(OP_VALIDATE, IDX_W'(1), 16'hAAAA, '0));
        void'(plan_req(OP_REMOVE, IDX_W'(1), 16'hAAAA, '0));
        void'(plan_req(OP_ALLOC, '0, '0, TEAM_W'(2)));                  // pops slot 1
        void'(plan_req(OP_VALIDATE, '1, '1, TEAM_W'(1)));               // top index, unused

        // random phases, each opened by a full drain of the pipeline
        for (int m = MODE_BUSY; m <= MODE_BOTH; m++) begin
            plan_mode  = m;
            plan_drain = 1'b1;
            repeat (35) plan_random();
        end

        // fill the map until allocate reports full
        plan_mode  = MODE_SNK_STALL;
        plan_drain = 1'b1;
        while (!(used_cnt[PLAN] == TABLE_SLOTS && stack_top[PLAN] == 0))
            void'(plan_req(OP_ALLOC, IDX_W'($urandom), GEN_W'($urandom), TEAM_W'($urandom)));
        void'(plan_req(OP_ALLOC, '0, '0, '0));
        void'(plan_req(OP_ALLOC, '1, '1, TEAM_W'(3)));
        void'(plan_req(OP_VALIDATE, '1, GEN_W'(1), TEAM_W'(2)));

        // a short mixed tail on the full map
        plan_mode = MODE_BOTH;
        repeat (20) plan_random();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (issue_q.size() > 0 || awaited_rsp.size() > 0 || i_in_valid)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
